@@ hw/rtl/vir94_pkg.sv @@
package vir94_pkg;

    // number system constants
    localparam int unsigned RADIX           = 94;
    localparam int unsigned CHAR_BASE       = 32;
    localparam int unsigned ZERO_DIGIT_CHAR = 126;
    localparam int unsigned MAX_DIGITS      = 5;

    // floor(2^32 / 94): reciprocal for the quotient estimate, error at most one
    localparam logic [25:0] RECIP_94 = 26'd45691141;
    // quotient taken after a zero value wraps down by the radix
    localparam logic [31:0] ZERO_WRAP_Q = 32'd45691140;

    // default depth of the value queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    // one input item
    typedef struct packed {
        logic [6:0] id_char;
        logic       id_last;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [6:0] out_char;
        logic       which_copy;
        logic       copy_end;
        logic       run_end;
    } t_out_item;

    // handoff from front to queue
    typedef struct packed {
        logic        push;
        logic [31:0] value;
    } t_push;

endpackage

@@ hw/rtl/vcd_id_remap_base94_core.sv @@
// Remaps waveform-dump signal identifiers held in bijective base 94.
// Input channel: one identifier character per item, first character first,
// with id_last on the final character. Output channel: the identifier for
// 2*value, then the one for 2*value+1, one character per item, least
// significant digit first, with copy_end on each identifier's last
// character and run_end on the last item of the pair.
// Characters are taken one per cycle while the value queue has room; only
// an item with id_last needs a queue entry, so ready drops only when the
// queue is full.
// Each result character passes the digit unit's reciprocal multiply stage,
// then its correction stage; a pair of identifiers also needs one fetch
// from the queue. The last character's value goes through the queue, the
// fetch and both stages before the first result reaches the output register.
// A stalled receiver holds the output register; the digit unit waits, and
// the front keeps accepting characters until the queue fills.
// Reset clears the accumulator to zero, the weight to one, and empties the
// queue and the output register.
module vcd_id_remap_base94_core
    import vir94_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_push       w_push;
    logic        w_full;
    logic        w_q_valid;
    logic [31:0] w_q_data;
    logic        w_q_pop;
    logic        w_accept;

    assign o_in_ready = ~w_full;
    assign w_accept   = i_in_valid & ~w_full;

    // accumulate characters
    vir94_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_data),
        .o_push   (w_push)
    );

    // values waiting for the digit unit
    vir94_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_q_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    // emit both identifiers
    vir94_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_data),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ hw/rtl/vir94_front.sv @@
module vir94_front
    import vir94_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_push    o_push
);

    logic [31:0] r_acc;
    logic [31:0] r_weight;
    logic [31:0] n_acc;
    logic [31:0] n_weight;
    logic [7:0]  w_digit;
    logic [31:0] w_digit_ext;
    logic [31:0] w_sum;

    // digit is the code minus the base, wrapped as a signed 8-bit value and sign-extended to 32 bits
    assign w_digit     = {1'b0, i_item.id_char} - 8'(CHAR_BASE);
    assign w_digit_ext = {{24{w_digit[7]}}, w_digit};
    assign w_sum       = r_acc + 32'(w_digit_ext * r_weight);

    // hand the doubled value to the queue on the last character
    assign o_push.push  = i_accept & i_item.id_last;
    assign o_push.value = {w_sum[30:0], 1'b0};

    // accumulator and running weight
    always_comb begin
        n_acc    = r_acc;
        n_weight = r_weight;
        if (i_accept) begin
            if (i_item.id_last) begin
                n_acc    = 32'd0;
                n_weight = 32'd1;
            end else begin
                n_acc    = w_sum;
                n_weight = 32'(r_weight * 32'(RADIX));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= 32'd0;
            r_weight <= 32'd1;
        end else begin
            r_acc    <= n_acc;
            r_weight <= n_weight;
        end
    end

endmodule

@@ hw/rtl/vir94_fifo.sv @@
module vir94_fifo
    import vir94_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_push       i_push,
    input  logic        i_pop,
    output logic        o_full,
    output logic        o_valid,
    output logic [31:0] o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [31:0]      r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push.push & ~o_full;
    assign w_rd    = i_pop & o_valid;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.value;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/vir94_back.sv @@
module vir94_back
    import vir94_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  logic [31:0] i_q_data,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_COR  = 3'b100
    } t_back_state;

    t_back_state r_state;
    t_back_state n_state;
    logic [31:0] r_v;
    logic [31:0] n_v;
    logic [31:0] r_base;
    logic [31:0] n_base;
    logic        r_copy;
    logic        n_copy;
    logic [2:0]  r_k;
    logic [2:0]  n_k;
    logic [25:0] r_qe;
    logic [25:0] n_qe;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [57:0] w_prod;
    logic [31:0] w_qm;
    logic [31:0] w_rem_full;
    logic [7:0]  w_rem_est;
    logic        w_fix;
    logic [25:0] w_q;
    logic [7:0]  w_rem;
    logic [6:0]  w_char;
    logic [31:0] w_nv;
    logic        w_done;
    logic        w_emit;

    // quotient estimate by reciprocal, registered before the correction
    assign w_prod = 58'(r_v) * 58'(RECIP_94);

    // correct the estimate by one step and form the digit
    assign w_qm       = 32'(32'(r_qe) * 32'(RADIX));
    assign w_rem_full = r_v - w_qm;
    assign w_rem_est  = w_rem_full[7:0];
    assign w_fix      = (w_rem_est >= 8'(RADIX));
    assign w_q        = w_fix ? r_qe + 26'd1 : r_qe;
    assign w_rem      = w_fix ? w_rem_est - 8'(RADIX) : w_rem_est;
    assign w_char     = (w_rem != 8'd0) ? 7'(w_rem + 8'(CHAR_BASE)) : 7'(ZERO_DIGIT_CHAR);

    // next value: zero remainder borrows one radix, zero value wraps
    always_comb begin
        if (w_rem != 8'd0) begin
            w_nv = {6'd0, w_q};
        end else if (r_v == 32'd0) begin
            w_nv = ZERO_WRAP_Q;
        end else begin
            w_nv = {6'd0, w_q} - 32'd1;
        end
    end

    assign w_done  = (w_nv == 32'd0) || (r_k == 3'(MAX_DIGITS - 1));
    assign w_emit  = (r_state == ST_COR) && (!r_out_valid || i_out_ready);
    assign o_q_pop = (r_state == ST_IDLE) && i_q_valid;

    // digit sequencer
    always_comb begin
        n_state = r_state;
        n_v     = r_v;
        n_base  = r_base;
        n_copy  = r_copy;
        n_k     = r_k;
        n_qe    = r_qe;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_v     = i_q_data;
                    n_base  = i_q_data;
                    n_copy  = 1'b0;
                    n_k     = 3'd0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_qe    = w_prod[57:32];
                n_state = ST_COR;
            end
            ST_COR: begin
                if (w_emit) begin
                    if (!w_done) begin
                        n_v     = w_nv;
                        n_k     = r_k + 3'd1;
                        n_state = ST_MUL;
                    end else if (!r_copy) begin
                        n_v     = r_base + 32'd1;
                        n_copy  = 1'b1;
                        n_k     = 3'd0;
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_v    <= n_v;
        r_base <= n_base;
        r_copy <= n_copy;
        r_k    <= n_k;
        r_qe   <= n_qe;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_emit) begin
            r_out.out_char   <= w_char;
            r_out.which_copy <= r_copy;
            r_out.copy_end   <= w_done;
            r_out.run_end    <= w_done & r_copy;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
